// ----- hdl/aabbmr_pkg.sv -----
// aabbmr_pkg: shared types and constants for the box move and resolve block
`default_nettype none
package aabbmr_pkg;

  // internal position width, units of 2^-17
  localparam int POS_W  = 36;
  // stored face width, 2*center +/- size
  localparam int FACE_W = 34;
  // product width of velocity times time step
  localparam int PROD_W = 49;
  // rounding shift from 2^-32 to 2^-17 units
  localparam int STEP_SHIFT = 15;

  // output saturation limits in internal width
  localparam logic signed [POS_W-1:0] OUT_MAX = POS_W'(32'sh7FFF_FFFF);
  localparam logic signed [POS_W-1:0] OUT_MIN = POS_W'(-64'sd2147483648);

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  typedef struct packed {
    logic               func;
    logic [3:0]         entry_index;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        delta_t;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               grounded;
  } out_item_t;

  // one platform as stored: faces in 2^-17 units
  typedef struct packed {
    logic signed [FACE_W-1:0] lo_x;
    logic signed [FACE_W-1:0] hi_x;
    logic signed [FACE_W-1:0] lo_y;
    logic signed [FACE_W-1:0] hi_y;
  } face_rec_t;

  localparam int FACE_REC_W = $bits(face_rec_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_SCAN_X,
    ST_SCAN_Y,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic step;
    logic stage_a;
    logic apply_x;
    logic apply_y;
    logic finish;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/aabb_move_and_resolve_top.sv -----
// aabb_move_and_resolve_top: platform table with a moving box resolved per item
// A load item writes its table entry at the accept edge; busy stays low after it.
// A move item keeps busy high until its result is strobed; n = entries in use sets its two scans;
// each table scan reads one entry per cycle through the ram read register and the widened face register.
// A new item may start in the strobe cycle; there is no result stall.
// Synchronous reset clears the controller and active_count; table contents are kept.
`default_nettype none
module aabb_move_and_resolve_top
  import aabbmr_pkg::*;
#(
  parameter int MAX_PLATFORMS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   item,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data,
  output logic            result_valid,
  output out_item_t       result
);

  localparam int ADDR_W = (MAX_PLATFORMS > 1) ? $clog2(MAX_PLATFORMS) : 1;

  ctrl_cmd_t         cmd;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  face_rec_t         wr_rec;
  face_rec_t         rd_rec;
  logic [FACE_REC_W-1:0] ram_rdata;

  // sequencer
  aabbmr_ctrl #(
    .MAX_PLATFORMS(MAX_PLATFORMS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (item.func),
    .entry_index(item.entry_index),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .busy       (busy),
    .cmd        (cmd),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_raddr  (ram_raddr)
  );

  // platform face table
  aabbmr_ram #(
    .WIDTH(FACE_REC_W),
    .DEPTH(MAX_PLATFORMS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_rec),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_rec = face_rec_t'(ram_rdata);

  // arithmetic
  aabbmr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .rd_rec      (rd_rec),
    .wr_rec      (wr_rec),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
`default_nettype wire

// ----- hdl/aabbmr_ram.sv -----
// aabbmr_ram: generic single write port ram with registered read
`default_nettype none
module aabbmr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/aabbmr_ctrl.sv -----
// aabbmr_ctrl: sequencer for load and move items and the two table scans
`default_nettype none
module aabbmr_ctrl
  import aabbmr_pkg::*;
#(
  parameter int MAX_PLATFORMS = 16,
  parameter int ADDR_W = (MAX_PLATFORMS > 1) ? $clog2(MAX_PLATFORMS) : 1,
  parameter int CNT_W  = $clog2(MAX_PLATFORMS + 2)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              func,
  input  wire logic [3:0]        entry_index,
  input  wire logic              cfg_wr_en,
  input  wire logic [4:0]        cfg_wr_data,
  output logic                   busy,
  output ctrl_cmd_t              cmd,
  output logic                   ram_we,
  output logic      [ADDR_W-1:0] ram_waddr,
  output logic      [ADDR_W-1:0] ram_raddr
);

  state_t           state, state_next;
  logic [4:0]       active_count;
  logic [CNT_W-1:0] scan_idx, scan_idx_next;
  logic [CNT_W-1:0] scan_n;
  logic             scan_last;
  logic             scanning;
  logic             rd_en;
  logic             rd_valid;
  logic             face_valid;
  logic             accept;
  logic             slot_ok;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // entries taking part, limited to the table depth
  always_comb begin
    if (9'(active_count) > 9'(MAX_PLATFORMS)) begin
      scan_n = CNT_W'(MAX_PLATFORMS);
    end else begin
      scan_n = CNT_W'(active_count);
    end
  end

  assign scanning  = (state == ST_SCAN_X) || (state == ST_SCAN_Y);
  assign scan_last = (scan_idx == scan_n + CNT_W'(1));
  assign rd_en     = scanning && (scan_idx < scan_n);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (cfg_wr_en) begin
      active_count <= cfg_wr_data;
    end
  end

  // table writes happen at accept of a load item
  assign slot_ok   = (9'(entry_index) < 9'(MAX_PLATFORMS));
  assign ram_we    = accept && (func == FUNC_LOAD) && slot_ok;
  assign ram_waddr = ADDR_W'(entry_index);
  assign ram_raddr = scan_idx[ADDR_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (func == FUNC_MOVE)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:    state_next = ST_STEP;
      ST_STEP:   state_next = ST_SCAN_X;
      ST_SCAN_X: begin
        if (scan_last) begin
          state_next = ST_SCAN_Y;
        end
      end
      ST_SCAN_Y: begin
        if (scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // scan counter
  always_comb begin
    if (scanning && !scan_last) begin
      scan_idx_next = scan_idx + CNT_W'(1);
    end else begin
      scan_idx_next = '0;
    end
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.capture = accept && (func == FUNC_MOVE);
    case (state)
      ST_MUL:    cmd.mul = 1'b1;
      ST_STEP:   cmd.step = 1'b1;
      ST_SCAN_X: begin
        cmd.stage_a = rd_valid;
        cmd.apply_x = face_valid;
      end
      ST_SCAN_Y: begin
        cmd.stage_a = rd_valid;
        cmd.apply_y = face_valid;
      end
      ST_FINISH: cmd.finish = 1'b1;
      default:   cmd.finish = 1'b0;
    endcase
  end

  // state and read pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      face_valid <= 1'b0;
    end else begin
      state      <= state_next;
      scan_idx   <= scan_idx_next;
      rd_valid   <= rd_en;
      face_valid <= rd_valid;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/aabbmr_datapath.sv -----
// aabbmr_datapath: step, face compare and clamp, output rounding
`default_nettype none
module aabbmr_datapath
  import aabbmr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  item,
  input  wire ctrl_cmd_t cmd,
  input  wire face_rec_t rd_rec,
  output face_rec_t      wr_rec,
  output logic           result_valid,
  output out_item_t      result
);

  logic signed [POS_W-1:0]  ox, oy, px, py;
  logic signed [POS_W-1:0]  hx, hy;
  logic signed [31:0]       vx, vy;
  logic        [15:0]       dt;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [POS_W-1:0]  ex_lo, ex_hi, ey_lo, ey_hi;
  logic                     bx, by, gr;
  logic signed [PROD_W-1:0] rnd_x, rnd_y;
  logic signed [POS_W-1:0]  step_x, step_y;
  logic                     ov_y, ov_x;

  // saturate to output q16.16 with round half up
  function automatic logic signed [31:0] to_out(input logic signed [POS_W-1:0] p);
    logic signed [POS_W-1:0] r;
    r = (p + POS_W'(1)) >>> 1;
    if (r > OUT_MAX) begin
      to_out = 32'sh7FFF_FFFF;
    end else if (r < OUT_MIN) begin
      to_out = 32'sh8000_0000;
    end else begin
      to_out = r[31:0];
    end
  endfunction

  // face record for a load item
  always_comb begin
    wr_rec.lo_x = {item.center_x[31], item.center_x, 1'b0} - FACE_W'(item.size_x);
    wr_rec.hi_x = {item.center_x[31], item.center_x, 1'b0} + FACE_W'(item.size_x);
    wr_rec.lo_y = {item.center_y[31], item.center_y, 1'b0} - FACE_W'(item.size_y);
    wr_rec.hi_y = {item.center_y[31], item.center_y, 1'b0} + FACE_W'(item.size_y);
  end

  // rounded steps from registered products
  assign rnd_x  = (prod_x + PROD_W'(1 << (STEP_SHIFT - 1))) >>> STEP_SHIFT;
  assign rnd_y  = (prod_y + PROD_W'(1 << (STEP_SHIFT - 1))) >>> STEP_SHIFT;
  assign step_x = rnd_x[POS_W-1:0];
  assign step_y = rnd_y[POS_W-1:0];

  // overlap tests for the two passes
  assign ov_y = (oy > ey_lo) && (oy < ey_hi);
  assign ov_x = (px > ex_lo) && (px < ex_hi);

  // body registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ox <= POS_W'($signed({item.center_x, 1'b0}));
      oy <= POS_W'($signed({item.center_y, 1'b0}));
      hx <= POS_W'(item.size_x);
      hy <= POS_W'(item.size_y);
      vx <= item.vel_x;
      vy <= item.vel_y;
      dt <= item.delta_t;
      bx <= 1'b0;
      by <= 1'b0;
      gr <= 1'b0;
    end
    if (cmd.mul) begin
      prod_x <= PROD_W'(vx * $signed({1'b0, dt}));
      prod_y <= PROD_W'(vy * $signed({1'b0, dt}));
    end
    if (cmd.step) begin
      px <= ox + step_x;
      py <= oy + step_y;
    end
    // horizontal clamp against one platform
    if (cmd.apply_x && ov_y) begin
      if ((vx > 0) && (ox <= ex_lo) && (px >= ex_lo)) begin
        px <= ex_lo;
        bx <= 1'b1;
      end else if ((vx < 0) && (ox >= ex_hi) && (px <= ex_hi)) begin
        px <= ex_hi;
        bx <= 1'b1;
      end
    end
    // vertical clamp: landing or ceiling
    if (cmd.apply_y && ov_x) begin
      if ((vy <= 0) && (oy >= ey_hi) && (py <= ey_hi)) begin
        py <= ey_hi;
        gr <= 1'b1;
        by <= 1'b1;
      end else if ((vy > 0) && (oy <= ey_lo) && (py >= ey_lo)) begin
        py <= ey_lo;
        by <= 1'b1;
      end
    end
  end

  // faces widened by the body half extents
  always_ff @(posedge clk) begin
    if (cmd.stage_a) begin
      ex_lo <= POS_W'(rd_rec.lo_x) - hx;
      ex_hi <= POS_W'(rd_rec.hi_x) + hx;
      ey_lo <= POS_W'(rd_rec.lo_y) - hy;
      ey_hi <= POS_W'(rd_rec.hi_y) + hy;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.new_x     <= to_out(px);
      result.new_y     <= to_out(py);
      result.new_vel_x <= bx ? 32'sd0 : vx;
      result.new_vel_y <= by ? 32'sd0 : vy;
      result.grounded  <= gr;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
    end
  end

endmodule
`default_nettype wire
